FILE: rtl/loocv_pkg.sv
// shared types and constants of the leave-one-out nearest neighbor accuracy block
package loocv_pkg;

    // default sizes of the data set stores
    localparam int MAX_INSTANCES_DEF = 1024;
    localparam int MAX_FEATURES_DEF  = 16;

    // fixed field widths
    localparam int LABEL_W  = 8;
    localparam int FEAT_W   = 16;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 11;
    localparam int ACC_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int SQ_W     = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // register byte addresses
    localparam logic [APB_AW-1:0] REG_FEATURE_MASK = 3'd0;

    // one input transfer
    typedef struct packed {
        logic [LABEL_W-1:0]       class_label;
        logic signed [FEAT_W-1:0] feature_value;
        logic                     last_feature;
        logic                     last_instance;
    } t_item;

    // one result transfer
    typedef struct packed {
        logic [CNT_W-1:0] correct_count;
        logic [CNT_W-1:0] instance_count;
        logic [ACC_W-1:0] accuracy_q16;
    } t_result;

endpackage

FILE: rtl/loocv_ram.sv
// generic single write, dual read RAM with registered read data
module loocv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/loocv_nearest_neighbor_accuracy.sv
// leave-one-out 1-nearest-neighbor accuracy scorer, top level
//
// A data set is loaded one feature value per start transfer, one per clock cycle while
// busy is low, into a feature memory and a label memory. The transfer with last_instance
// set ends the set and starts scoring, and busy stays high until the result has been shown.
// The pairwise pass visits n*n*F feature pairs, where n is the instance count and F is
// min(MAX_FEATURES, 16); the feature memory delivers one feature of instance i and one of
// instance j per cycle through its two read ports. A bit-serial divider then forms the
// Q1.16 accuracy. With an empty feature mask the pairwise pass is skipped. The result is
// shown for one cycle with o_done and must be taken then; it cannot be held off.
// feature_mask is read at the start of scoring, so write it while busy is low.
module loocv_nearest_neighbor_accuracy #(
    parameter int MAX_INSTANCES = loocv_pkg::MAX_INSTANCES_DEF,
    parameter int MAX_FEATURES  = loocv_pkg::MAX_FEATURES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            start,
    output logic                            busy,
    input  loocv_pkg::t_item                i_item,
    // result channel
    output logic                            o_done,
    output loocv_pkg::t_result              o_result,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [loocv_pkg::APB_AW-1:0]    paddr,
    input  logic [loocv_pkg::APB_DW-1:0]    pwdata,
    output logic [loocv_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);

    import loocv_pkg::*;

    localparam int IW     = $clog2(MAX_INSTANCES);
    localparam int CW     = $clog2(MAX_INSTANCES + 1);
    localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int LFW    = $clog2(MAX_FEATURES + 1);
    localparam int NFU    = (MAX_FEATURES < MASK_W) ? MAX_FEATURES : MASK_W;
    localparam int SFW    = (NFU > 1) ? $clog2(NFU) : 1;
    localparam int DIST_W = SQ_W + $clog2(NFU);
    localparam int FDEPTH = MAX_INSTANCES * (2 ** FW);
    localparam int DVW    = CW + FRAC_W;
    localparam int DCW    = $clog2(DVW + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // control travelling with each feature pair through the distance pipeline
    typedef struct packed {
        logic v;
        logic ne;
        logic sel;
        logic first;
        logic last_f;
        logic last_j;
    } t_tag;

    logic [2:0]          r_state;
    logic [MASK_W-1:0]   r_mask;
    logic [CW-1:0]       r_ld_inst, n_ld_inst;
    logic [LFW-1:0]      r_ld_feat, n_ld_feat;
    logic [CW-1:0]       r_n;
    logic [NFU-1:0]      r_smask;
    logic [IW-1:0]       r_si, r_sj, n_si, n_sj;
    logic [SFW-1:0]      r_sf, n_sf;
    t_tag                w_t0, r_t1, r_t2, r_t3;
    logic                r_c_v, r_c_ne, r_c_last;
    logic [CW-1:0]       r_correct;
    logic                r_have;

    logic signed [16:0]  r_diff;
    logic signed [33:0]  w_prod;
    logic [SQ_W-1:0]     r_sq;
    logic [LABEL_W-1:0]  r_lj2, r_li2, r_lj3, r_li3, r_lj4, r_li4, r_best_lab;
    logic [DIST_W-1:0]   r_acc, n_acc, r_dist, r_best;
    logic [CW-1:0]       r_rem;
    logic [DVW-1:0]      r_dq;
    logic [DCW-1:0]      r_div_cnt;

    logic                w_accept, w_inst_ok, w_feat_ok, w_end_inst;
    logic                w_fwe, w_lwe;
    logic [CW-1:0]       w_n_count;
    logic                w_last_f, w_last_j, w_last_i;
    logic                w_pipe_busy;
    logic [FEAT_W-1:0]   w_feat_j, w_feat_i;
    logic [LABEL_W-1:0]  w_lab_j, w_lab_i;
    logic                w_take, w_have;
    logic [LABEL_W-1:0]  w_blab;
    logic [CW:0]         w_shift;
    logic                w_ge;
    logic                w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == REG_FEATURE_MASK) ? APB_DW'(r_mask) : '0;

    // load side bookkeeping
    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_inst_ok  = (r_ld_inst < CW'(MAX_INSTANCES));
    assign w_feat_ok  = (r_ld_feat < LFW'(MAX_FEATURES));
    assign w_end_inst = i_item.last_feature || i_item.last_instance;
    assign w_fwe      = w_accept && w_inst_ok && w_feat_ok;
    assign w_lwe      = w_accept && w_inst_ok;
    assign w_n_count  = r_ld_inst + CW'(w_inst_ok);

    always_comb begin
        n_ld_inst = r_ld_inst;
        n_ld_feat = r_ld_feat;
        if (w_accept) begin
            if (i_item.last_instance) begin
                n_ld_inst = '0;
                n_ld_feat = '0;
            end else if (w_end_inst) begin
                n_ld_inst = r_ld_inst + CW'(w_inst_ok);
                n_ld_feat = '0;
            end else if (w_feat_ok) begin
                n_ld_feat = r_ld_feat + LFW'(1);
            end
        end
    end

    // pair sequencer: f innermost, then j, then i
    assign w_last_f = (r_sf == SFW'(NFU - 1));
    assign w_last_j = (CW'(r_sj) == r_n - CW'(1));
    assign w_last_i = (CW'(r_si) == r_n - CW'(1));

    always_comb begin
        n_sf = r_sf;
        n_sj = r_sj;
        n_si = r_si;
        if (w_last_f) begin
            n_sf = '0;
            if (w_last_j) begin
                n_sj = '0;
                n_si = r_si + IW'(1);
            end else begin
                n_sj = r_sj + IW'(1);
            end
        end else begin
            n_sf = r_sf + SFW'(1);
        end
    end

    assign w_t0.v      = (r_state == S_RUN);
    assign w_t0.ne     = (r_si != r_sj);
    assign w_t0.sel    = (r_si != r_sj) && r_smask[r_sf];
    assign w_t0.first  = (r_sf == '0);
    assign w_t0.last_f = w_last_f;
    assign w_t0.last_j = w_last_j;

    // feature and label memories
    loocv_ram #(
        .WIDTH (FEAT_W),
        .DEPTH (FDEPTH)
    ) u_feat_ram (
        .i_clk     (i_clk),
        .i_we      (w_fwe),
        .i_waddr   ({r_ld_inst[IW-1:0], r_ld_feat[FW-1:0]}),
        .i_wdata   (i_item.feature_value),
        .i_raddr_a ({r_sj, FW'(r_sf)}),
        .i_raddr_b ({r_si, FW'(r_sf)}),
        .o_rdata_a (w_feat_j),
        .o_rdata_b (w_feat_i)
    );

    loocv_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_INSTANCES)
    ) u_label_ram (
        .i_clk     (i_clk),
        .i_we      (w_lwe),
        .i_waddr   (r_ld_inst[IW-1:0]),
        .i_wdata   (i_item.class_label),
        .i_raddr_a (r_sj),
        .i_raddr_b (r_si),
        .o_rdata_a (w_lab_j),
        .o_rdata_b (w_lab_i)
    );

    // squaring and accumulation
    assign w_prod = r_diff * r_diff;
    assign n_acc  = (r_t3.first ? '0 : r_acc) + (r_t3.sel ? DIST_W'(r_sq) : '0);

    // nearest neighbor update, strictly smaller wins
    assign w_take = r_c_ne && (!r_have || (r_dist < r_best));
    assign w_have = r_have || w_take;
    assign w_blab = w_take ? r_lj4 : r_best_lab;

    assign w_pipe_busy = r_t1.v || r_t2.v || r_t3.v || r_c_v;

    // restoring division step
    assign w_shift = {r_rem, r_dq[DVW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_n});

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mask    <= '1;
            r_ld_inst <= '0;
            r_ld_feat <= '0;
            r_n       <= '0;
            r_smask   <= '0;
            r_si      <= '0;
            r_sj      <= '0;
            r_sf      <= '0;
            r_t1      <= '0;
            r_t2      <= '0;
            r_t3      <= '0;
            r_c_v     <= 1'b0;
            r_correct <= '0;
            r_have    <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            if (w_cfg_wr && (paddr == REG_FEATURE_MASK)) begin
                r_mask <= pwdata[MASK_W-1:0];
            end
            r_ld_inst <= n_ld_inst;
            r_ld_feat <= n_ld_feat;
            r_t1      <= w_t0;
            r_t2      <= r_t1;
            r_t3      <= r_t2;
            r_c_v     <= r_t3.v && r_t3.last_f;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_item.last_instance) begin
                        r_n       <= w_n_count;
                        r_smask   <= r_mask[NFU-1:0];
                        r_correct <= '0;
                        r_have    <= 1'b0;
                        r_si      <= '0;
                        r_sj      <= '0;
                        r_sf      <= '0;
                        r_state   <= (r_mask[NFU-1:0] == '0) ? S_DRAIN : S_RUN;
                    end
                end
                S_RUN: begin
                    r_si <= n_si;
                    r_sj <= n_sj;
                    r_sf <= n_sf;
                    if (w_last_f && w_last_j && w_last_i) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!w_pipe_busy) begin
                        r_div_cnt <= DCW'(DVW);
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt - DCW'(1);
                    if (r_div_cnt == DCW'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // close out one instance after its last candidate
            if (r_c_v) begin
                if (r_c_last) begin
                    r_have <= 1'b0;
                    if (w_have && (w_blab == r_li4)) begin
                        r_correct <= r_correct + CW'(1);
                    end
                end else begin
                    r_have <= w_have;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_diff <= $signed({w_feat_i[FEAT_W-1], w_feat_i} - {w_feat_j[FEAT_W-1], w_feat_j});
        r_lj2  <= w_lab_j;
        r_li2  <= w_lab_i;
        r_sq   <= w_prod[SQ_W-1:0];
        r_lj3  <= r_lj2;
        r_li3  <= r_li2;
        if (r_t3.v) begin
            r_acc <= n_acc;
        end
        if (r_t3.v && r_t3.last_f) begin
            r_dist   <= n_acc;
            r_lj4    <= r_lj3;
            r_li4    <= r_li3;
            r_c_ne   <= r_t3.ne;
            r_c_last <= r_t3.last_j;
        end
        if (r_c_v && w_take) begin
            r_best     <= r_dist;
            r_best_lab <= r_lj4;
        end
        if ((r_state == S_DRAIN) && !w_pipe_busy) begin
            r_rem <= '0;
            r_dq  <= {r_correct, {FRAC_W{1'b0}}};
        end else if (r_state == S_DIV) begin
            r_rem <= w_ge ? CW'(w_shift - {1'b0, r_n}) : CW'(w_shift);
            r_dq  <= {r_dq[DVW-2:0], w_ge};
        end
    end

    // result transfer
    assign o_done                  = (r_state == S_OUT);
    assign o_result.correct_count  = CNT_W'(r_correct);
    assign o_result.instance_count = CNT_W'(r_n);
    assign o_result.accuracy_q16   = (r_n == '0) ? '0 : r_dq[ACC_W-1:0];

    // correct count can never pass the instance count
    a_correct_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_correct <= r_n))
        else $error("correct count exceeds instance count");

    // no store write while scoring reads the memories
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fwe || w_lwe) |-> (r_state == S_IDLE))
        else $error("store written during scoring");

    // the divider starts only once the distance pipeline has drained
    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !w_pipe_busy)
        else $error("division started with pipeline busy");

    // accuracy never above one
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.accuracy_q16 <= 17'h10000))
        else $error("accuracy out of range");

endmodule
